FILE: src/huffman_stream_decoder_core_defines.svh
// assertion macros for the huffman stream decoder checker
// no dependencies; included by the checker file only
`ifndef HUFFMAN_STREAM_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HSD_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("huffman decoder check failed");

// next-cycle implication, reset masks the check
`define HSD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("huffman decoder check failed");

`endif

FILE: src/hsd_pkg.sv
// shared types and codes for the huffman stream decoder
// no dependencies
`timescale 1ns / 1ps

package hsd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TREE,
    PH_DATA,
    PH_DRAIN
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PAD   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] PAD_MAX   = 8'd8;
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [3:0] SYM_BITS  = 4'd8;

endpackage

FILE: src/hsd_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module hsd_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int DW    = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/huffman_stream_decoder_core.sv
// huffman stream decoder top level: byte sequencer, tree builder and code walker
// depends on hsd_pkg and hsd_ram
`timescale 1ns / 1ps

// Usage:
// - input channel s_*: one compressed byte per request, msb first; s_tlast marks
//   the last byte of a stream
// - output channel m_*: decoded symbols (m_tuser 0) and one status result
//   (m_tuser 1) per stream; m_tlast marks the last result caused by a byte
// - the first three bytes are each taken straight from S_IDLE; a tree bit is handled
//   in S_BIT, then S_POP when a leaf ends and a right link is popped from the stack
//   memory; a code bit passes S_BIT (node table read), then S_WALK (step)
// - any other byte holds s_tready low from its request until its bits are done,
//   longer while the receiver stalls; s_tready is high only between bytes
// - a symbol is held one step so the last result of a byte can carry m_tlast
// - a stalled receiver stalls the walk once the symbol holding slot is full;
//   nothing is dropped
// - rst is synchronous; after it and after each final byte the block waits
//   for a new header; the memories are not cleared
module huffman_stream_decoder_core #(
  parameter int NODE_COUNT  = 512,
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // symbol[7:0], status[10:8], zero[15:11]
  output logic        m_tuser,   // result_kind[0]
  output logic        m_tlast
);

  localparam int AW  = $clog2(NODE_COUNT);
  localparam int LW  = $clog2(NODE_COUNT + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int EW  = 1 + 8 + 2 * LW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_POP,
    S_WALK,
    S_END
  } state_t;

  state_t          state, state_next;
  hsd_pkg::phase_t phase, phase_next;
  logic [1:0]      hc, hc_next;
  logic [3:0]      pad, pad_next;
  logic [15:0]     tbl, tbl_next;
  logic [LW-1:0]   nfree, nfree_next;
  logic [SW-1:0]   sp, sp_next;
  logic [7:0]      lshift, lshift_next;
  logic [3:0]      lleft, lleft_next;
  logic [2:0]      err, err_next;
  logic            root_leaf, root_leaf_next;
  logic [LW-1:0]   root_right, root_right_next;
  logic [LW-1:0]   cur_left, cur_left_next;
  logic [LW-1:0]   cur_right, cur_right_next;
  logic            at_root, at_root_next;
  logic [7:0]      sh, sh_next;
  logic [3:0]      cnt, cnt_next;
  logic            fin, fin_next;
  logic            pend_v, pend_v_next;
  logic [7:0]      pend_sym, pend_sym_next;
  logic            out_v_next;
  logic [15:0]     out_data_next;
  logic            out_user_next, out_last_next;

  logic            node_we, node_re, stk_we, stk_re;
  logic [AW-1:0]   node_waddr, node_raddr;
  logic [EW-1:0]   node_wdata, node_rdata;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [AW-1:0]   stk_wdata, stk_rdata;

  logic            bit_v, out_free, alloc_ok, push_ok, nxt_ok, do_adv;
  logic [LW-1:0]   nxt;
  logic [15:0]     tbl_dec, tbl_full;
  logic [2:0]      fin_status;

  hsd_ram #(.DEPTH(NODE_COUNT), .AW(AW), .DW(EW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  hsd_ram #(.DEPTH(STACK_DEPTH), .AW(SAW), .DW(AW)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign bit_v    = sh[7];
  assign out_free = !m_tvalid || m_tready;
  assign alloc_ok = nfree < LW'(NODE_COUNT);
  assign push_ok  = sp < SW'(STACK_DEPTH);
  assign nxt      = bit_v ? cur_right : cur_left;
  assign nxt_ok   = nxt < LW'(NODE_COUNT);
  assign tbl_dec  = tbl - 16'd1;
  assign tbl_full = {tbl[15:8], s_tdata};

  always_comb begin
    fin_status = err;
    if (err == hsd_pkg::ST_OK && (phase != hsd_pkg::PH_DATA || !at_root)) begin
      fin_status = hsd_pkg::ST_TRUNCATED;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    hc_next         = hc;
    pad_next        = pad;
    tbl_next        = tbl;
    nfree_next      = nfree;
    sp_next         = sp;
    lshift_next     = lshift;
    lleft_next      = lleft;
    err_next        = err;
    root_leaf_next  = root_leaf;
    root_right_next = root_right;
    cur_left_next   = cur_left;
    cur_right_next  = cur_right;
    at_root_next    = at_root;
    sh_next         = sh;
    cnt_next        = cnt;
    fin_next        = fin;
    pend_v_next     = pend_v;
    pend_sym_next   = pend_sym;
    out_v_next      = m_tvalid && !m_tready;
    out_data_next   = m_tdata;
    out_user_next   = m_tuser;
    out_last_next   = m_tlast;
    node_we         = 1'b0;
    node_waddr      = nfree[AW-1:0];
    node_wdata      = '0;
    node_re         = 1'b0;
    node_raddr      = nxt[AW-1:0];
    stk_we          = 1'b0;
    stk_waddr       = sp[SAW-1:0];
    stk_wdata       = nfree[AW-1:0];
    stk_re          = 1'b0;
    stk_raddr       = SAW'(sp - SW'(1));
    do_adv          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          fin_next = s_tlast;
          if (phase == hsd_pkg::PH_HEADER) begin
            unique case (hc)
              2'd0: begin
                if (s_tdata > hsd_pkg::PAD_MAX) begin
                  pad_next = 4'd0;
                  if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_BAD_PAD;
                  phase_next = hsd_pkg::PH_DRAIN;
                end else begin
                  pad_next = s_tdata[3:0];
                  hc_next  = 2'd1;
                end
              end
              2'd1: begin
                tbl_next = {s_tdata, 8'd0};
                hc_next  = 2'd2;
              end
              default: begin
                tbl_next = tbl_full;
                hc_next  = 2'd0;
                if (tbl_full == 16'd0) begin
                  if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_MISMATCH;
                  phase_next = hsd_pkg::PH_DRAIN;
                end else begin
                  phase_next = hsd_pkg::PH_TREE;
                end
              end
            endcase
            state_next = s_tlast ? S_END : S_IDLE;
          end else begin
            sh_next    = s_tdata;
            cnt_next   = s_tlast ? hsd_pkg::BYTE_BITS - pad : hsd_pkg::BYTE_BITS;
            state_next = (s_tlast && pad == hsd_pkg::BYTE_BITS) ? S_END : S_BIT;
          end
        end
      end
      S_BIT: begin
        priority if (phase == hsd_pkg::PH_TREE) begin
          do_adv = 1'b1;
          if (lleft != 4'd0) begin
            lshift_next = {lshift[6:0], bit_v};
            lleft_next  = lleft - 4'd1;
            if (lleft == 4'd1) begin
              node_we    = 1'b1;
              node_waddr = AW'(nfree - LW'(1));
              node_wdata = {1'b1, lshift[6:0], bit_v, {(2 * LW){1'b0}}};
              if (sp == '0) begin
                tbl_next = tbl_dec;
                if (tbl_dec != 16'd0) begin
                  if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_MISMATCH;
                  phase_next = hsd_pkg::PH_DRAIN;
                end else begin
                  phase_next     = hsd_pkg::PH_DATA;
                  at_root_next   = 1'b1;
                  cur_left_next  = LW'(1);
                  cur_right_next = root_right;
                end
              end else begin
                stk_re     = 1'b1;
                sp_next    = sp - SW'(1);
                do_adv     = 1'b0;
                state_next = S_POP;
              end
            end else begin
              tbl_next = tbl_dec;
              if (tbl_dec == 16'd0) begin
                if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_MISMATCH;
                phase_next = hsd_pkg::PH_DRAIN;
              end
            end
          end else if (!alloc_ok) begin
            if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_OVERFLOW;
            phase_next = hsd_pkg::PH_DRAIN;
          end else begin
            nfree_next = nfree + LW'(1);
            if (nfree == '0) root_leaf_next = bit_v;
            if (bit_v) begin
              lleft_next  = hsd_pkg::SYM_BITS;
              lshift_next = 8'd0;
            end
            if (!bit_v && !push_ok) begin
              if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_OVERFLOW;
              phase_next = hsd_pkg::PH_DRAIN;
            end else begin
              if (!bit_v) begin
                node_we    = 1'b1;
                node_wdata = {1'b0, 8'd0, nfree + LW'(1), {LW{1'b0}}};
                stk_we     = 1'b1;
                sp_next    = sp + SW'(1);
              end
              tbl_next = tbl_dec;
              if (tbl_dec == 16'd0) begin
                if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_MISMATCH;
                phase_next = hsd_pkg::PH_DRAIN;
              end
            end
          end
        end else if (phase == hsd_pkg::PH_DATA && !root_leaf && nxt_ok) begin
          node_re    = 1'b1;
          state_next = S_WALK;
        end else begin
          do_adv = 1'b1;
        end
      end
      S_POP: begin
        do_adv     = 1'b1;
        node_we    = 1'b1;
        node_waddr = stk_rdata;
        node_wdata = {1'b0, 8'd0, LW'(stk_rdata) + LW'(1), nfree};
        if (stk_rdata == '0) root_right_next = nfree;
        tbl_next = tbl_dec;
        if (tbl_dec == 16'd0) begin
          if (err == hsd_pkg::ST_OK) err_next = hsd_pkg::ST_MISMATCH;
          phase_next = hsd_pkg::PH_DRAIN;
        end
      end
      S_WALK: begin
        if (node_rdata[EW-1]) begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              out_v_next    = 1'b1;
              out_data_next = {5'd0, hsd_pkg::ST_OK, pend_sym};
              out_user_next = hsd_pkg::KIND_SYMBOL;
              out_last_next = 1'b0;
            end
            pend_v_next    = 1'b1;
            pend_sym_next  = node_rdata[EW-2 -: 8];
            at_root_next   = 1'b1;
            cur_left_next  = LW'(1);
            cur_right_next = root_right;
            do_adv         = 1'b1;
          end
        end else begin
          cur_left_next  = node_rdata[2*LW-1:LW];
          cur_right_next = node_rdata[LW-1:0];
          at_root_next   = 1'b0;
          do_adv         = 1'b1;
        end
      end
      S_END: begin
        if (pend_v) begin
          if (out_free) begin
            out_v_next    = 1'b1;
            out_data_next = {5'd0, hsd_pkg::ST_OK, pend_sym};
            out_user_next = hsd_pkg::KIND_SYMBOL;
            out_last_next = !fin;
            pend_v_next   = 1'b0;
          end
        end else if (fin) begin
          if (out_free) begin
            out_v_next    = 1'b1;
            out_data_next = {5'd0, fin_status, 8'd0};
            out_user_next = hsd_pkg::KIND_STATUS;
            out_last_next = 1'b1;
            phase_next    = hsd_pkg::PH_HEADER;
            hc_next       = 2'd0;
            pad_next      = 4'd0;
            tbl_next      = 16'd0;
            nfree_next    = '0;
            sp_next       = '0;
            lshift_next   = 8'd0;
            lleft_next    = 4'd0;
            err_next      = hsd_pkg::ST_OK;
            at_root_next  = 1'b1;
            fin_next      = 1'b0;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (do_adv) begin
      sh_next    = {sh[6:0], 1'b0};
      cnt_next   = cnt - 4'd1;
      state_next = (cnt == 4'd1) ? S_END : S_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= hsd_pkg::PH_HEADER;
      hc         <= 2'd0;
      pad        <= 4'd0;
      tbl        <= 16'd0;
      nfree      <= '0;
      sp         <= '0;
      lshift     <= 8'd0;
      lleft      <= 4'd0;
      err        <= hsd_pkg::ST_OK;
      at_root    <= 1'b1;
      fin        <= 1'b0;
      pend_v     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      hc         <= hc_next;
      pad        <= pad_next;
      tbl        <= tbl_next;
      nfree      <= nfree_next;
      sp         <= sp_next;
      lshift     <= lshift_next;
      lleft      <= lleft_next;
      err        <= err_next;
      at_root    <= at_root_next;
      fin        <= fin_next;
      pend_v     <= pend_v_next;
      m_tvalid   <= out_v_next;
    end
    root_leaf  <= root_leaf_next;
    root_right <= root_right_next;
    cur_left   <= cur_left_next;
    cur_right  <= cur_right_next;
    sh         <= sh_next;
    cnt        <= cnt_next;
    pend_sym   <= pend_sym_next;
    m_tdata    <= out_data_next;
    m_tuser    <= out_user_next;
    m_tlast    <= out_last_next;
  end

endmodule

FILE: src/hsd_checker.sv
// port level checks for the huffman stream decoder, bound to the top level
// depends on hsd_pkg and huffman_stream_decoder_core_defines.svh
`timescale 1ns / 1ps
`include "huffman_stream_decoder_core_defines.svh"

module hsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic in_req;
  logic fin_req;

  assign in_req  = s_tvalid && s_tready && (s_tdata == s_tdata);
  assign fin_req = in_req && s_tlast;

  `HSD_ASSERT_IMPLY(a_status_closes, clk, rst,
    m_tvalid && m_tuser == hsd_pkg::KIND_STATUS, m_tlast && m_tdata[7:0] == 8'd0)
  `HSD_ASSERT_IMPLY(a_symbol_clean, clk, rst,
    m_tvalid && m_tuser == hsd_pkg::KIND_SYMBOL, m_tdata[15:8] == 8'd0)
  `HSD_ASSERT_IMPLY(a_status_range, clk, rst,
    m_tvalid, m_tdata[10:8] <= hsd_pkg::ST_TRUNCATED)
  `HSD_ASSERT_NEXT(a_final_busy, clk, rst, fin_req, !s_tready)
  `HSD_ASSERT_NEXT(a_stall_hold, clk, rst,
    m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind huffman_stream_decoder_core hsd_checker u_hsd_checker (.*);
